/* rtl/assert_macros.svh */
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pidrl_pkg.sv */
// Types, register indexes and saturating helpers for the rate-limited PID core.
package pidrl_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned STEP_W  = 31;
   localparam int unsigned PROD_W  = 64;
   localparam int unsigned Q_SHIFT = 16;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KP_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_STEP_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_MIN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_MAX    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MIN      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MAX      = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_ERROR,
      ST_MUL_P,
      ST_P_TERM,
      ST_MUL_I,
      ST_I_ADD,
      ST_I_CLAMP,
      ST_D_DIFF,
      ST_MUL_D,
      ST_D_TERM,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_KP,
      MUL_KI,
      MUL_KD
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        limit;
      logic        error;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        p_en;
      logic        i_add;
      logic        i_clamp;
      logic        d_diff;
      logic        d_en;
      logic        sum_en;
      logic        out_load;
   } cmd_type;

   // Saturate a 34-bit signed value to 32 bits.
   function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
      logic signed [DATA_W-1:0] r;
      if ((v[DATA_W+1:DATA_W-1] == 3'b000) || (v[DATA_W+1:DATA_W-1] == 3'b111)) begin
         r = v[DATA_W-1:0];
      end else begin
         r = v[DATA_W+1] ? MIN_VAL : MAX_VAL;
      end
      return r;
   endfunction

   // Q16.16 product scaling: arithmetic shift (floor) then saturate.
   function automatic logic signed [DATA_W-1:0] qsat(input logic signed [PROD_W-1:0] p);
      logic signed [DATA_W-1:0] r;
      if ((p[PROD_W-1:DATA_W+Q_SHIFT-1] == '0) || (p[PROD_W-1:DATA_W+Q_SHIFT-1] == '1)) begin
         r = p[DATA_W+Q_SHIFT-1:Q_SHIFT];
      end else begin
         r = p[PROD_W-1] ? MIN_VAL : MAX_VAL;
      end
      return r;
   endfunction

   // Low bound is checked first: with inverted bounds, a value below it gets the low bound, any other the high bound.
   function automatic logic signed [DATA_W-1:0] clamp32(
      input logic signed [DATA_W-1:0] v,
      input logic signed [DATA_W-1:0] lo,
      input logic signed [DATA_W-1:0] hi
   );
      logic signed [DATA_W-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W+1:0] sx34(input logic signed [DATA_W-1:0] v);
      return {{2{v[DATA_W-1]}}, v};
   endfunction

endpackage

/* rtl/pidrl_datapath.sv */
// Datapath: control registers, loop state, shared multiplier and result registers.
module pidrl_datapath #(
   parameter int SERIAL_FORM = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pidrl_pkg::cmd_type                     cmd,
   input  logic                                   csr_we,
   input  logic [pidrl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pidrl_pkg::DATA_W-1:0]           csr_data,
   input  logic [3*pidrl_pkg::DATA_W-1:0]         in_data,
   output logic [2*pidrl_pkg::DATA_W-1:0]         out_data
);

   localparam int W = pidrl_pkg::DATA_W;

   // Control registers
   logic signed [W-1:0] kp_ff, ki_ff, kd_ff;
   logic [pidrl_pkg::STEP_W-1:0] step_max_ff;
   logic signed [W-1:0] integ_min_ff, integ_max_ff, out_min_ff, out_max_ff;

   // Loop state
   logic signed [W-1:0] integ_ff, integ_in;
   logic signed [W-1:0] prev_d_ff;
   logic signed [W-1:0] prev_ref_ff;

   // Per-sample working registers
   logic signed [W-1:0] ref_ff, fdb_ff, ffd_ff;
   logic signed [W-1:0] ref_lim_ff, ref_lim_in;
   logic signed [W-1:0] err_ff;
   logic signed [W-1:0] p_ff, d_ff, ddiff_ff;
   logic signed [W+1:0] sum_ff;
   logic signed [pidrl_pkg::PROD_W-1:0] prod_ff;
   logic signed [W-1:0] drive_ff, drive_unclamped_ff;

   logic signed [W-1:0] mul_a, mul_b;
   logic signed [W-1:0] i_in, d_in, sum_sat;
   logic signed [W:0]   change, step_x, step_neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         step_max_ff  <= '0;
         integ_min_ff <= pidrl_pkg::MIN_VAL;
         integ_max_ff <= pidrl_pkg::MAX_VAL;
         out_min_ff   <= pidrl_pkg::MIN_VAL;
         out_max_ff   <= pidrl_pkg::MAX_VAL;
      end else if (csr_we) begin
         unique case (csr_index)
            pidrl_pkg::CSR_KP_GAIN:      kp_ff        <= csr_data;
            pidrl_pkg::CSR_INTEG_GAIN:   ki_ff        <= csr_data;
            pidrl_pkg::CSR_DIFF_GAIN:    kd_ff        <= csr_data;
            pidrl_pkg::CSR_REF_STEP_MAX: step_max_ff  <= csr_data[pidrl_pkg::STEP_W-1:0];
            pidrl_pkg::CSR_INTEG_MIN:    integ_min_ff <= csr_data;
            pidrl_pkg::CSR_INTEG_MAX:    integ_max_ff <= csr_data;
            pidrl_pkg::CSR_OUT_MIN:      out_min_ff   <= csr_data;
            pidrl_pkg::CSR_OUT_MAX:      out_max_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Reference slew limit against the previous limited reference.
   always_comb begin
      change   = {ref_ff[W-1], ref_ff} - {prev_ref_ff[W-1], prev_ref_ff};
      step_x   = {2'b00, step_max_ff};
      step_neg = -step_x;
      if ((step_max_ff != '0) && (change > step_x)) begin
         ref_lim_in = pidrl_pkg::sat34(pidrl_pkg::sx34(prev_ref_ff) + {3'b000, step_max_ff});
      end else if ((step_max_ff != '0) && (change < step_neg)) begin
         ref_lim_in = pidrl_pkg::sat34(pidrl_pkg::sx34(prev_ref_ff) - {3'b000, step_max_ff});
      end else begin
         ref_lim_in = ref_ff;
      end
   end

   assign i_in = (SERIAL_FORM != 0)
      ? pidrl_pkg::sat34(pidrl_pkg::sx34(err_ff) + pidrl_pkg::sx34(p_ff)) : err_ff;
   assign d_in = (SERIAL_FORM != 0)
      ? pidrl_pkg::sat34(pidrl_pkg::sx34(err_ff) + pidrl_pkg::sx34(integ_ff)) : err_ff;

   always_comb begin
      unique case (cmd.mul_sel)
         pidrl_pkg::MUL_KP: begin
            mul_a = kp_ff;
            mul_b = err_ff;
         end
         pidrl_pkg::MUL_KI: begin
            mul_a = ki_ff;
            mul_b = i_in;
         end
         pidrl_pkg::MUL_KD: begin
            mul_a = kd_ff;
            mul_b = ddiff_ff;
         end
         default: begin
            mul_a = kp_ff;
            mul_b = err_ff;
         end
      endcase
   end

   // Integrator: saturated add, then clamp in the following step.
   always_comb begin
      integ_in = integ_ff;
      if (cmd.i_add) begin
         integ_in = pidrl_pkg::sat34(pidrl_pkg::sx34(integ_ff)
                                     + pidrl_pkg::sx34(pidrl_pkg::qsat(prod_ff)));
      end else if (cmd.i_clamp) begin
         integ_in = pidrl_pkg::clamp32(integ_ff, integ_min_ff, integ_max_ff);
      end
   end

   assign sum_sat = pidrl_pkg::sat34(sum_ff);

   // Loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         prev_d_ff   <= '0;
         prev_ref_ff <= '0;
      end else begin
         integ_ff <= integ_in;
         if (cmd.limit) begin
            prev_ref_ff <= ref_lim_in;
         end
         if (cmd.d_diff) begin
            prev_d_ff <= d_in;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         ref_ff <= in_data[W-1:0];
         fdb_ff <= in_data[2*W-1:W];
         ffd_ff <= in_data[3*W-1:2*W];
      end
      if (cmd.limit) begin
         ref_lim_ff <= ref_lim_in;
      end
      if (cmd.error) begin
         err_ff <= pidrl_pkg::sat34(pidrl_pkg::sx34(ref_lim_ff) - pidrl_pkg::sx34(fdb_ff));
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.p_en) begin
         p_ff <= pidrl_pkg::qsat(prod_ff);
      end
      if (cmd.d_diff) begin
         ddiff_ff <= pidrl_pkg::sat34(pidrl_pkg::sx34(d_in) - pidrl_pkg::sx34(prev_d_ff));
      end
      if (cmd.d_en) begin
         d_ff <= pidrl_pkg::qsat(prod_ff);
      end
      if (cmd.sum_en) begin
         // exact four-term sum; 34 bits cannot overflow
         sum_ff <= pidrl_pkg::sx34(p_ff) + pidrl_pkg::sx34(integ_ff)
                 + pidrl_pkg::sx34(d_ff) + pidrl_pkg::sx34(ffd_ff);
      end
      if (cmd.out_load) begin
         drive_ff           <= pidrl_pkg::clamp32(sum_sat, out_min_ff, out_max_ff);
         drive_unclamped_ff <= sum_sat;
      end
   end

   assign out_data = {drive_unclamped_ff, drive_ff};

endmodule

/* rtl/pidrl_ctrl.sv */
// Controller: sequences one control step and owns the result valid flag.
module pidrl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output pidrl_pkg::cmd_type cmd
);

   pidrl_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidrl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pidrl_pkg::ST_IDLE:    if (req_tvalid) state_in = pidrl_pkg::ST_LIMIT;
         pidrl_pkg::ST_LIMIT:   state_in = pidrl_pkg::ST_ERROR;
         pidrl_pkg::ST_ERROR:   state_in = pidrl_pkg::ST_MUL_P;
         pidrl_pkg::ST_MUL_P:   state_in = pidrl_pkg::ST_P_TERM;
         pidrl_pkg::ST_P_TERM:  state_in = pidrl_pkg::ST_MUL_I;
         pidrl_pkg::ST_MUL_I:   state_in = pidrl_pkg::ST_I_ADD;
         pidrl_pkg::ST_I_ADD:   state_in = pidrl_pkg::ST_I_CLAMP;
         pidrl_pkg::ST_I_CLAMP: state_in = pidrl_pkg::ST_D_DIFF;
         pidrl_pkg::ST_D_DIFF:  state_in = pidrl_pkg::ST_MUL_D;
         pidrl_pkg::ST_MUL_D:   state_in = pidrl_pkg::ST_D_TERM;
         pidrl_pkg::ST_D_TERM:  state_in = pidrl_pkg::ST_SUM;
         pidrl_pkg::ST_SUM:     state_in = pidrl_pkg::ST_OUT;
         pidrl_pkg::ST_OUT:     if (out_free) state_in = pidrl_pkg::ST_IDLE;
         default:               state_in = pidrl_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd         = '0;
      cmd.mul_sel = pidrl_pkg::MUL_KP;
      req_tready  = 1'b0;
      unique case (state_ff)
         pidrl_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         pidrl_pkg::ST_LIMIT:   cmd.limit = 1'b1;
         pidrl_pkg::ST_ERROR:   cmd.error = 1'b1;
         pidrl_pkg::ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pidrl_pkg::MUL_KP;
         end
         pidrl_pkg::ST_P_TERM:  cmd.p_en = 1'b1;
         pidrl_pkg::ST_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pidrl_pkg::MUL_KI;
         end
         pidrl_pkg::ST_I_ADD:   cmd.i_add = 1'b1;
         pidrl_pkg::ST_I_CLAMP: cmd.i_clamp = 1'b1;
         pidrl_pkg::ST_D_DIFF:  cmd.d_diff = 1'b1;
         pidrl_pkg::ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pidrl_pkg::MUL_KD;
         end
         pidrl_pkg::ST_D_TERM:  cmd.d_en = 1'b1;
         pidrl_pkg::ST_SUM:     cmd.sum_en = 1'b1;
         pidrl_pkg::ST_OUT:     cmd.out_load = out_free;
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* rtl/pid_controller_rate_limited_core.sv */
// Top level of the rate-limited PID controller core with integrator clamp.
//
// Usage:
//   req_* : one beat per control sample; tdata = reference, feedback, feedforward
//           (signed Q16.16, reference in the low 32 bits).
//   rsp_* : one beat per sample; tdata = drive (clamped) low, drive_unclamped high.
//   csr_* : register writes, index 0..7 = kp_gain, integ_gain, diff_gain,
//           ref_step_max, integ_min, integ_max, out_min, out_max. Always ready;
//           write only while no sample is in flight.
// Sequence: one sample is worked at a time through 12 controller steps that
//   share a single 32x32 multiplier (P, I and D products in turn); the
//   result is registered and rsp_tvalid rises once the final step loads it.
//   A new sample is taken only after the previous one leaves the final step.
// Stall: the result sits in an output register; the core takes the next
//   sample while it waits and only holds in its final step if a second
//   result is ready before the first was taken.
// Reset: synchronous, active high; clears integrator, derivative history,
//   previous reference and the result valid flag; gains and step limit go to
//   zero, clamp bounds to the full 32-bit range.
`include "assert_macros.svh"

module pid_controller_rate_limited_core #(
   parameter int SERIAL_FORM = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   // reference[31:0], feedback[63:32], feedforward[95:64]
   input  logic [3*pidrl_pkg::DATA_W-1:0]      req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // drive[31:0], drive_unclamped[63:32]
   output logic [2*pidrl_pkg::DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pidrl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pidrl_pkg::DATA_W-1:0]        csr_data
);

   pidrl_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   pidrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   pidrl_datapath #(
      .SERIAL_FORM (SERIAL_FORM)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_data   (req_tdata),
      .out_data  (rsp_tdata)
   );

   // A sample in flight blocks the next one.
   `ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "accepted while busy")
   // A fresh result appears exactly as the controller returns to idle.
   `ASSERT_IMPL(a_result_at_idle, $rose(rsp_tvalid), req_tready, "result without idle")
   // A pending result is never overwritten.
   `ASSERT_IMPL(a_no_overwrite, cmd.out_load, !rsp_tvalid || rsp_tready, "result overwritten")

endmodule

/* bench/testbench.sv */
// Self-checking bench for the rate-limited PID core: streams samples, checks every drive beat.
module testbench;

   localparam int SERIAL_FORM = 0;
   localparam int IDLE_PCT = 37;
   localparam int CYCLE_LIMIT = 300000;
   // Margin after the last drain before the run finishes.
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_SAMPLES = 115;

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   localparam logic [31:0] ONE = 32'h0001_0000;   // 1.0 in Q16.16

   // Packed so that reference lands in the low bits of the bus.
   typedef struct packed {
      logic signed [pidrl_pkg::DATA_W-1:0] feedforward;
      logic signed [pidrl_pkg::DATA_W-1:0] feedback;
      logic signed [pidrl_pkg::DATA_W-1:0] reference;
   } sample_type;

   typedef struct packed {
      logic signed [pidrl_pkg::DATA_W-1:0] drive_unclamped;
      logic signed [pidrl_pkg::DATA_W-1:0] drive;
   } drive_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // reference[31:0], feedback[63:32], feedforward[95:64]
   sample_type req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // drive[31:0], drive_unclamped[63:32]
   drive_type rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pidrl_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pidrl_pkg::DATA_W-1:0] csr_data = '0;

   sample_type sample_q[$];    // samples waiting to be offered
   drive_type drive_q[$];      // predicted drive beats, oldest first
   bit gaps_on = 1'b1;      // random bubbles on both sides
   int mismatches = 0;
   int cycles = 0;

   // Controller image: settings as written, plus loop state.
   longint kp = 0, ki = 0, kd = 0, step_lim = 0;
   longint i_lo = Q_MIN, i_hi = Q_MAX, o_lo = Q_MIN, o_hi = Q_MAX;
   longint integ = 0, diff_hold = 0, ref_hold = 0;

   pid_controller_rate_limited_core #(
      .SERIAL_FORM(SERIAL_FORM)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint sat_q(longint v);
      if (v > Q_MAX) begin
         return Q_MAX;
      end else if (v < Q_MIN) begin
         return Q_MIN;
      end
      return v;
   endfunction

   // Exact product, floor shift by 16 (>>> on a 64-bit signed value), saturate.
   function automatic longint qprod(longint a, longint b);
      return sat_q((a * b) >>> pidrl_pkg::Q_SHIFT);
   endfunction

   // Low check first: with inverted bounds, below-min wins, else max.
   function automatic longint bound(longint v, longint lo, longint hi);
      if (v < lo) begin
         return lo;
      end else if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   function automatic void apply_reg(logic [pidrl_pkg::CSR_IDX_W-1:0] idx,
                                     logic [pidrl_pkg::DATA_W-1:0] data);
      case (idx)
         pidrl_pkg::CSR_KP_GAIN: begin
            kp = longint'($signed(data));
         end
         pidrl_pkg::CSR_INTEG_GAIN: begin
            ki = longint'($signed(data));
         end
         pidrl_pkg::CSR_DIFF_GAIN: begin
            kd = longint'($signed(data));
         end
         pidrl_pkg::CSR_REF_STEP_MAX: begin
            step_lim = longint'(data[pidrl_pkg::STEP_W-1:0]);   // bit 31 dropped
         end
         pidrl_pkg::CSR_INTEG_MIN: begin
            i_lo = longint'($signed(data));
         end
         pidrl_pkg::CSR_INTEG_MAX: begin
            i_hi = longint'($signed(data));
         end
         pidrl_pkg::CSR_OUT_MIN: begin
            o_lo = longint'($signed(data));
         end
         pidrl_pkg::CSR_OUT_MAX: begin
            o_hi = longint'($signed(data));
         end
         default: begin
         end
      endcase
   endfunction

   // One control step: advances the loop state and returns the drive beat.
   function automatic drive_type control_step(sample_type s);
      longint tgt, fdb, ffd, chg, err, p, i_in, d_in, d, total;
      drive_type o;
      tgt = longint'(s.reference);
      fdb = longint'(s.feedback);
      ffd = longint'(s.feedforward);
      if (step_lim > 0) begin
         chg = tgt - ref_hold;
         if (chg > step_lim) begin
            tgt = sat_q(ref_hold + step_lim);
         end else if (chg < -step_lim) begin
            tgt = sat_q(ref_hold - step_lim);
         end
      end
      ref_hold = tgt;
      err = sat_q(tgt - fdb);
      p = qprod(kp, err);
      i_in = (SERIAL_FORM != 0) ? sat_q(err + p) : err;
      integ = bound(sat_q(integ + qprod(ki, i_in)), i_lo, i_hi);
      d_in = (SERIAL_FORM != 0) ? sat_q(err + integ) : err;
      d = qprod(kd, sat_q(d_in - diff_hold));
      diff_hold = d_in;
      // four terms summed exactly, saturated once
      total = sat_q(p + integ + d + ffd);
      o.drive = pidrl_pkg::DATA_W'(bound(total, o_lo, o_hi));
      o.drive_unclamped = pidrl_pkg::DATA_W'(total);
      return o;
   endfunction

   function automatic sample_type sample_of(logic [31:0] tgt, logic [31:0] fdb,
                                            logic [31:0] ffd);
      sample_type s;
      s.reference = tgt;
      s.feedback = fdb;
      s.feedforward = ffd;
      return s;
   endfunction

   // Q16.16 value: mostly within +-32.0, sometimes a rail or raw bits.
   function automatic logic [31:0] rand_q16();
      case ($urandom_range(15))
         0: return pidrl_pkg::MAX_VAL;
         1: return pidrl_pkg::MIN_VAL;
         2, 3, 4: return $urandom;
         default: return int'($urandom_range(32'h0040_0000)) - 32'h0020_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_gain();
      case ($urandom_range(7))
         0: return $urandom;
         1: return '0;
         default: return int'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
      endcase
   endfunction

   task automatic pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
      logic signed [31:0] a, b;
      a = rand_q16();
      b = rand_q16();
      case ($urandom_range(5))
         0: begin
            lo = pidrl_pkg::MIN_VAL;
            hi = pidrl_pkg::MAX_VAL;
         end
         1: begin
            // inverted on purpose
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
         end
         default: begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
         end
      endcase
   endtask

   // Called just after a rising edge; leaves csr_valid high for a following write.
   task automatic write_reg(logic [pidrl_pkg::CSR_IDX_W-1:0] idx,
                            logic [pidrl_pkg::DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
   endtask

   task automatic load_settings(logic [31:0] kp_v, logic [31:0] ki_v, logic [31:0] kd_v,
                                logic [31:0] step_v, logic [31:0] ilo_v, logic [31:0] ihi_v,
                                logic [31:0] olo_v, logic [31:0] ohi_v);
      write_reg(pidrl_pkg::CSR_KP_GAIN, kp_v);
      write_reg(pidrl_pkg::CSR_INTEG_GAIN, ki_v);
      write_reg(pidrl_pkg::CSR_DIFF_GAIN, kd_v);
      write_reg(pidrl_pkg::CSR_REF_STEP_MAX, step_v);
      write_reg(pidrl_pkg::CSR_INTEG_MIN, ilo_v);
      write_reg(pidrl_pkg::CSR_INTEG_MAX, ihi_v);
      write_reg(pidrl_pkg::CSR_OUT_MIN, olo_v);
      write_reg(pidrl_pkg::CSR_OUT_MAX, ohi_v);
      csr_valid <= 1'b0;
   endtask

   // Block until every queued sample is in and every drive beat is back.
   // Checked mid-cycle so the edge's updates have settled; returns after a rising edge.
   task automatic drain();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_tvalid || drive_q.size() != 0);
      @(posedge clock);
   endtask

   initial begin
      logic [31:0] ilo, ihi, olo, ohi;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: zero gains, so drive is just feedforward.
      sample_q.push_back(sample_of(pidrl_pkg::MAX_VAL, pidrl_pkg::MIN_VAL, pidrl_pkg::MAX_VAL));
      sample_q.push_back(sample_of(pidrl_pkg::MIN_VAL, pidrl_pkg::MAX_VAL, pidrl_pkg::MIN_VAL));
      sample_q.push_back(sample_of('0, '0, 32'hFFFF_FFFF));
      drain();

      // Moderate gains, 2.0 step limit, +-8 integrator, +-10 output.
      load_settings(ONE, 32'h0000_4000, 32'h0000_8000, 32'h0002_0000,
                    32'hFFF8_0000, 32'h0008_0000, 32'hFFF6_0000, 32'h000A_0000);
      sample_q.push_back(sample_of(32'h0064_0000, '0, '0));          // limited up
      sample_q.push_back(sample_of(32'h0064_0000, '0, '0));
      sample_q.push_back(sample_of(32'hFF9C_0000, '0, '0));          // limited down
      sample_q.push_back(sample_of(32'h0003_0000, 32'h0003_0000, '0));
      sample_q.push_back(sample_of('0, 32'h0000_0001, 32'h0014_0000)); // output high rail
      sample_q.push_back(sample_of('0, '0, 32'hFFEC_0000));          // output low rail
      drain();

      // Rails everywhere; bit 31 of the step limit is dropped; both clamps inverted.
      load_settings(pidrl_pkg::MAX_VAL, pidrl_pkg::MAX_VAL, pidrl_pkg::MIN_VAL, 32'hFFFF_FFFF,
                    ONE, -ONE, pidrl_pkg::MAX_VAL, pidrl_pkg::MIN_VAL);
      sample_q.push_back(sample_of(pidrl_pkg::MAX_VAL, pidrl_pkg::MIN_VAL, pidrl_pkg::MAX_VAL));
      sample_q.push_back(sample_of(pidrl_pkg::MIN_VAL, pidrl_pkg::MAX_VAL, pidrl_pkg::MIN_VAL));
      sample_q.push_back(sample_of(pidrl_pkg::MIN_VAL, pidrl_pkg::MIN_VAL, '0));
      sample_q.push_back(sample_of(pidrl_pkg::MAX_VAL, pidrl_pkg::MAX_VAL, pidrl_pkg::MAX_VAL));
      sample_q.push_back(sample_of('0, 32'h0000_0001, 32'hFFFF_FFFF));
      sample_q.push_back(sample_of(32'h0000_0001, '0, '0));
      drain();

      // Most negative P and I gains, most positive D gain, one-LSB step limit, zero-width output window.
      load_settings(pidrl_pkg::MIN_VAL, pidrl_pkg::MIN_VAL, pidrl_pkg::MAX_VAL, 32'h0000_0001,
                    pidrl_pkg::MIN_VAL, pidrl_pkg::MAX_VAL, '0, '0);
      sample_q.push_back(sample_of(pidrl_pkg::MAX_VAL, '0, '0));
      sample_q.push_back(sample_of(pidrl_pkg::MIN_VAL, 32'h0000_0003, '0));
      sample_q.push_back(sample_of(pidrl_pkg::MIN_VAL, pidrl_pkg::MIN_VAL, pidrl_pkg::MAX_VAL));
      sample_q.push_back(sample_of(32'h0000_0007, 32'hFFFF_FFFD, pidrl_pkg::MIN_VAL));
      drain();

      // Random settings and samples; one phase runs without bubbles.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         pick_bounds(ilo, ihi);
         pick_bounds(olo, ohi);
         case ($urandom_range(3))
            0: load_settings(rand_gain(), rand_gain(), rand_gain(), '0, ilo, ihi, olo, ohi);
            1: load_settings(rand_gain(), rand_gain(), rand_gain(), $urandom,
                             ilo, ihi, olo, ohi);
            default: load_settings(rand_gain(), rand_gain(), rand_gain(),
                                   $urandom_range(32'h0004_0000), ilo, ihi, olo, ohi);
         endcase
         gaps_on = (ph != 2);
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            sample_q.push_back(sample_of(rand_q16(), rand_q16(), rand_q16()));
         end
         drain();
      end
      gaps_on = 1'b1;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Sample driver: predicts on acceptance, then offers the next sample or a bubble.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            drive_q.push_back(control_step(req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (sample_q.size() != 0 && (!gaps_on || $urandom_range(99) >= IDLE_PCT)) begin
               req_tdata <= sample_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Drive beat checker.
   always @(posedge clock) begin : drive_check
      drive_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_q.size() == 0) begin
            $error("drive beat with nothing predicted: drive %0d", rsp_tdata.drive);
            mismatches++;
         end else begin
            want = drive_q.pop_front();
            if (rsp_tdata.drive !== want.drive) begin
               $error("drive: expected %0d, actual %0d", want.drive, rsp_tdata.drive);
               mismatches++;
            end
            if (rsp_tdata.drive_unclamped !== want.drive_unclamped) begin
               $error("drive_unclamped: expected %0d, actual %0d",
                      want.drive_unclamped, rsp_tdata.drive_unclamped);
               mismatches++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pidrl_pkg.sv
rtl/pidrl_datapath.sv
rtl/pidrl_ctrl.sv
rtl/pid_controller_rate_limited_core.sv
bench/testbench.sv
